/* src/cart_bank_mapper_defines.svh */
`ifndef CART_BANK_MAPPER_DEFINES_SVH
`define CART_BANK_MAPPER_DEFINES_SVH

// checked only out of reset
`define CBM_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// checked on every edge, reset included
`define CBM_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

/* src/cbm_pkg.sv */
`timescale 1ns / 1ps

package cbm_pkg;

   localparam int ROM_BANK_BITS = 5;
   localparam int RAM_BANK_BITS = 2;
   localparam int ADDR_W        = 16;
   localparam int DATA_W        = 8;
   localparam int PHYS_W        = 20;
   localparam int REQ_TDATA_W   = 32;
   localparam int RSP_TDATA_W   = 32;
   localparam int CSR_INDEX_W   = 1;
   localparam int CSR_DATA_W    = 8;
   localparam int RAM_OFFSET_W  = 13;
   localparam int ROM_OFFSET_W  = 14;

   localparam logic OP_READ  = 1'b0;
   localparam logic OP_WRITE = 1'b1;

   localparam logic [1:0] TGT_NONE = 2'd0;
   localparam logic [1:0] TGT_ROM  = 2'd1;
   localparam logic [1:0] TGT_RAM  = 2'd2;
   localparam logic [1:0] TGT_OPEN = 2'd3;

   localparam logic [CSR_INDEX_W-1:0] CSR_CART_TYPE = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_RAM_SIZE  = 1'd1;

   localparam logic [7:0] CART_MBC_FIRST = 8'd1;
   localparam logic [7:0] CART_MBC_LAST  = 8'd3;
   localparam logic [7:0] CART_SAVE_TYPE = 8'd3;

   localparam logic [7:0] RAM_SIZE_1BANK  = 8'd2;
   localparam logic [7:0] RAM_SIZE_4BANK  = 8'd3;
   localparam logic [7:0] RAM_SIZE_16BANK = 8'd4;
   localparam logic [7:0] RAM_SIZE_8BANK  = 8'd5;

   localparam logic [ADDR_W-1:0] REGION_MASK   = 16'hE000;
   localparam logic [ADDR_W-1:0] REGION_RAMEN  = 16'h0000;
   localparam logic [ADDR_W-1:0] REGION_ROMB   = 16'h2000;
   localparam logic [ADDR_W-1:0] REGION_RAMB   = 16'h4000;
   localparam logic [ADDR_W-1:0] REGION_MODE   = 16'h6000;
   localparam logic [ADDR_W-1:0] REGION_RAM    = 16'hA000;
   localparam logic [ADDR_W-1:0] ROM_BANK_BASE = 16'h4000;
   localparam logic [3:0]        RAM_KEY       = 4'hA;

   typedef struct packed {
      logic [DATA_W-1:0] bus_data;
      logic [ADDR_W-1:0] bus_address;
      logic              op;
   } cbm_item_type;

   typedef struct packed {
      logic              save_request;
      logic [DATA_W-1:0] ram_data;
      logic              ram_write;
      logic [PHYS_W-1:0] phys_address;
      logic [1:0]        target;
   } cbm_result_type;

   function automatic logic bank_present(input logic [7:0] code,
                                         input logic [RAM_BANK_BITS-1:0] bank);
      logic [31:0] b;
      b = 32'(bank);
      case (code)
         RAM_SIZE_1BANK:  return b == 32'd0;
         RAM_SIZE_4BANK:  return b < 32'd4;
         RAM_SIZE_16BANK: return b < 32'd16;
         RAM_SIZE_8BANK:  return b < 32'd8;
         default:         return 1'b0;
      endcase
   endfunction

endpackage

/* src/cart_bank_mapper.sv */
`timescale 1ns / 1ps
// An accepted req item passes through the input register, then the result register, to rsp_tvalid.
// Throughput: 1 item per cycle; decode and bank-state update finish in the single pass
// between the two registers; req_tready drops only while both registers are full and
// rsp_tready is low.
// Reset (synchronous, active high): both pipeline stages empty, cart_type and
// ram_size_code 0, ROM bank 1, RAM disabled, RAM bank 0, mode 0, dirty clear.

module cart_bank_mapper (
   input  logic                            clock,
   input  logic                            reset,
   // req_tdata: op[0], bus_address[16:1], bus_data[24:17], ignored [31:25]
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [cbm_pkg::REQ_TDATA_W-1:0] req_tdata,
   // rsp_tdata: target[1:0], phys_address[21:2], ram_write[22], ram_data[30:23],
   // save_request[31]
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [cbm_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   input  logic                            csr_we,
   input  logic [cbm_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [cbm_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import cbm_pkg::*;

   logic           s1_valid;
   logic           s2_ready;
   cbm_item_type   s1_item;
   cbm_result_type s1_result;

   cbm_in_stage u_in (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .down_ready (s2_ready),
      .valid      (s1_valid),
      .item       (s1_item)
   );

   cbm_core u_core (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .item      (s1_item),
      .fire      (s1_valid && s2_ready),
      .result    (s1_result)
   );

   cbm_out_stage u_out (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (s1_valid),
      .in_ready   (s2_ready),
      .result     (s1_result),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

/* src/cbm_in_stage.sv */
`timescale 1ns / 1ps

module cbm_in_stage (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [cbm_pkg::REQ_TDATA_W-1:0] req_tdata,
   input  logic                          down_ready,
   output logic                          valid,
   output cbm_pkg::cbm_item_type         item
);
   import cbm_pkg::*;

   logic         valid_ff;
   logic         valid_in;
   cbm_item_type item_ff;

   assign req_tready = !valid_ff || down_ready;

   always_comb begin
      valid_in = valid_ff;
      if (req_tready) begin
         valid_in = req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         item_ff <= cbm_item_type'(req_tdata[$bits(cbm_item_type)-1:0]);
      end
   end

   assign valid = valid_ff;
   assign item  = item_ff;

endmodule

/* src/cbm_core.sv */
`timescale 1ns / 1ps

module cbm_core (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_we,
   input  logic [cbm_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [cbm_pkg::CSR_DATA_W-1:0]  csr_wdata,
   input  cbm_pkg::cbm_item_type           item,
   input  logic                            fire,
   output cbm_pkg::cbm_result_type         result
);
   import cbm_pkg::*;

   logic [7:0]               cart_type_ff;
   logic [7:0]               ram_size_code_ff;
   logic                     ram_enable_ff, ram_enable_in;
   logic [ROM_BANK_BITS-1:0] rom_bank_ff, rom_bank_in;
   logic [RAM_BANK_BITS-1:0] ram_bank_select_ff, ram_bank_select_in;
   logic                     banking_mode_ff, banking_mode_in;
   logic [RAM_BANK_BITS-1:0] active_ram_bank_ff, active_ram_bank_in;
   logic                     dirty_ff, dirty_in;

   logic                     mapper_on;
   logic                     ram_ok;
   logic [ADDR_W-1:0]        region;
   logic [ROM_BANK_BITS-1:0] rom_sel;
   logic [PHYS_W-1:0]        rom_phys;
   logic [PHYS_W-1:0]        ram_phys;

   always_ff @(posedge clock) begin
      if (reset) begin
         cart_type_ff     <= 8'd0;
         ram_size_code_ff <= 8'd0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_CART_TYPE: cart_type_ff     <= csr_wdata;
            CSR_RAM_SIZE:  ram_size_code_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      mapper_on = cart_type_ff inside {[CART_MBC_FIRST:CART_MBC_LAST]};
      ram_ok    = ram_enable_ff && bank_present(ram_size_code_ff, active_ram_bank_ff);
      region    = item.bus_address & REGION_MASK;
      rom_sel   = item.bus_data[ROM_BANK_BITS-1:0];
      rom_phys  = PHYS_W'({rom_bank_ff, {ROM_OFFSET_W{1'b0}}})
                + PHYS_W'(item.bus_address - ROM_BANK_BASE);
      ram_phys  = PHYS_W'({active_ram_bank_ff, item.bus_address[RAM_OFFSET_W-1:0]});

      ram_enable_in      = ram_enable_ff;
      rom_bank_in        = rom_bank_ff;
      ram_bank_select_in = ram_bank_select_ff;
      banking_mode_in    = banking_mode_ff;
      active_ram_bank_in = active_ram_bank_ff;
      dirty_in           = dirty_ff;
      result             = '0;

      if (item.op == OP_READ) begin
         if (!mapper_on || item.bus_address < ROM_BANK_BASE) begin
            result.target       = TGT_ROM;
            result.phys_address = PHYS_W'(item.bus_address);
         end else if (region == REGION_RAM) begin
            if (ram_ok) begin
               result.target       = TGT_RAM;
               result.phys_address = ram_phys;
            end else begin
               result.target = TGT_OPEN;
            end
         end else begin
            result.target       = TGT_ROM;
            result.phys_address = rom_phys;
         end
      end else if (mapper_on) begin
         case (region)
            REGION_RAMEN: begin
               ram_enable_in = item.bus_data[3:0] == RAM_KEY;
            end
            REGION_ROMB: begin
               rom_bank_in = (rom_sel == '0) ? ROM_BANK_BITS'(1) : rom_sel;
            end
            REGION_RAMB: begin
               ram_bank_select_in = item.bus_data[RAM_BANK_BITS-1:0];
               if (banking_mode_ff) begin
                  active_ram_bank_in  = item.bus_data[RAM_BANK_BITS-1:0];
                  result.save_request = dirty_ff;
               end
            end
            REGION_MODE: begin
               banking_mode_in = item.bus_data[0];
               if (item.bus_data[0]) begin
                  active_ram_bank_in  = ram_bank_select_ff;
                  result.save_request = dirty_ff;
               end
            end
            REGION_RAM: begin
               if (ram_ok) begin
                  result.target       = TGT_RAM;
                  result.phys_address = ram_phys;
                  result.ram_write    = 1'b1;
                  result.ram_data     = item.bus_data;
                  if (cart_type_ff == CART_SAVE_TYPE) begin
                     dirty_in = 1'b1;
                  end
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ram_enable_ff      <= 1'b0;
         rom_bank_ff        <= ROM_BANK_BITS'(1);
         ram_bank_select_ff <= '0;
         banking_mode_ff    <= 1'b0;
         active_ram_bank_ff <= '0;
         dirty_ff           <= 1'b0;
      end else if (fire) begin
         ram_enable_ff      <= ram_enable_in;
         rom_bank_ff        <= rom_bank_in;
         ram_bank_select_ff <= ram_bank_select_in;
         banking_mode_ff    <= banking_mode_in;
         active_ram_bank_ff <= active_ram_bank_in;
         dirty_ff           <= dirty_in;
      end
   end

endmodule

/* src/cbm_out_stage.sv */
`timescale 1ns / 1ps

module cbm_out_stage (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            in_valid,
   output logic                            in_ready,
   input  cbm_pkg::cbm_result_type         result,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [cbm_pkg::RSP_TDATA_W-1:0] rsp_tdata
);
   import cbm_pkg::*;

   logic           valid_ff;
   logic           valid_in;
   cbm_result_type result_ff;

   assign in_ready = !valid_ff || rsp_tready;

   always_comb begin
      valid_in = valid_ff;
      if (in_ready) begin
         valid_in = in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         result_ff <= result;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = RSP_TDATA_W'(result_ff);

endmodule

/* src/cbm_checker.sv */
`timescale 1ns / 1ps
`include "cart_bank_mapper_defines.svh"

module cbm_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [cbm_pkg::RSP_TDATA_W-1:0] rsp_tdata
);
   import cbm_pkg::*;

   `CBM_ASSERT_ALWAYS(a_empty_after_reset, $past(reset) |-> !rsp_tvalid, "rsp valid right after reset")
   `CBM_ASSERT(a_hold_on_stall, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata), "stalled rsp item changed")
   `CBM_ASSERT(a_none_no_addr, rsp_tvalid && rsp_tdata[1:0] == TGT_NONE |-> rsp_tdata[21:2] == '0, "address on target none")
   `CBM_ASSERT(a_write_is_ram, rsp_tvalid && rsp_tdata[22] |-> rsp_tdata[1:0] == TGT_RAM, "RAM strobe outside RAM")
   `CBM_ASSERT(a_data_only_on_write, rsp_tvalid && !rsp_tdata[22] |-> rsp_tdata[30:23] == '0, "RAM data without strobe")

endmodule

bind cart_bank_mapper cbm_checker u_cbm_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
